@@ sv/eacb_pkg.sv @@
// Package with shared types, status codes and denomination tables for the change breakdown unit.
`timescale 1ns / 1ps

package eacb_pkg;

  // Longest euro part in digits.
  localparam int MAX_EURO_DIGITS = 7;

  // Number of denominations and the index of the last euro coin.
  localparam int NUM_DENOMS  = 15;
  localparam logic [3:0] LAST_EURO_IDX  = 4'd8;
  localparam logic [3:0] LAST_DENOM_IDX = 4'd14;
  localparam logic [3:0] NO_TOP_IDX     = 4'd9;

  // Status codes of a result.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR    = 3'd1;
  localparam logic [2:0] ST_CENT_DIGITS = 3'd2;
  localparam logic [2:0] ST_BAD_TOP     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG    = 3'd4;

  // ASCII codes the parser looks for.
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;
  localparam logic [7:0] CHR_DOT   = 8'd46;
  localparam logic [7:0] CHR_COMMA = 8'd44;

  // One parsed amount, handed from the parser to the breakdown engine.
  typedef struct packed {
    logic [23:0] euro_total;
    logic [6:0]  cent_total;
    logic [3:0]  start_idx;
    logic [2:0]  error_code;
  } job_t;

  // Face value of each denomination, in euros for 0..8 and in cents for 9..14.
  function automatic logic [8:0] denom_value(input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd500;
      4'd1:    v = 9'd200;
      4'd2:    v = 9'd100;
      4'd3:    v = 9'd50;
      4'd4:    v = 9'd20;
      4'd5:    v = 9'd10;
      4'd6:    v = 9'd5;
      4'd7:    v = 9'd2;
      4'd8:    v = 9'd1;
      4'd9:    v = 9'd50;
      4'd10:   v = 9'd20;
      4'd11:   v = 9'd10;
      4'd12:   v = 9'd5;
      4'd13:   v = 9'd2;
      default: v = 9'd1;
    endcase
    return v;
  endfunction

  // Reciprocal floor((2^32 - 1) / value); the estimate it gives is low by at most one.
  function automatic logic [31:0] denom_recip(input logic [3:0] idx);
    logic [31:0] r;
    case (idx)
      4'd0:          r = 32'd8589934;
      4'd1:          r = 32'd21474836;
      4'd2:          r = 32'd42949672;
      4'd3, 4'd9:    r = 32'd85899345;
      4'd4, 4'd10:   r = 32'd214748364;
      4'd5, 4'd11:   r = 32'd429496729;
      4'd6, 4'd12:   r = 32'd858993459;
      4'd7, 4'd13:   r = 32'd2147483647;
      default:       r = 32'd4294967295;
    endcase
    return r;
  endfunction

  // Denomination index of the requested top note; NO_TOP_IDX when it is not a note or coin.
  function automatic logic [3:0] top_index(input logic [8:0] top);
    logic [3:0] i;
    case (top)
      9'd500:  i = 4'd0;
      9'd200:  i = 4'd1;
      9'd100:  i = 4'd2;
      9'd50:   i = 4'd3;
      9'd20:   i = 4'd4;
      9'd10:   i = 4'd5;
      9'd5:    i = 4'd6;
      9'd2:    i = 4'd7;
      9'd1:    i = 4'd8;
      default: i = NO_TOP_IDX;
    endcase
    return i;
  endfunction

endpackage

@@ sv/eacb_front.sv @@
// Character parser: accumulates euros and cents, tracks the first error and emits one job per amount.
`timescale 1ns / 1ps

module eacb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  input  logic [8:0]        top_note,
  output logic              push,
  output eacb_pkg::job_t    job
);
  import eacb_pkg::*;

  logic [23:0] euro_r, euro_nxt;
  logic [6:0]  cent_r, cent_nxt;
  logic        frac_r, frac_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        is_digit;
  logic        is_sep;
  logic [3:0]  digit;
  logic [3:0]  start_idx;

  assign is_digit  = (char_code >= CHR_ZERO) && (char_code <= CHR_NINE);
  assign is_sep    = (char_code == CHR_DOT) || (char_code == CHR_COMMA);
  assign digit     = 4'(char_code - CHR_ZERO);
  assign start_idx = top_index(top_note);

  // Next amount state for the current character; only the first error is kept.
  always_comb begin
    euro_nxt = euro_r;
    cent_nxt = cent_r;
    frac_nxt = frac_r;
    err_nxt  = err_r;
    cnt_nxt  = cnt_r;
    if (is_digit) begin
      if (!frac_r) begin
        if (cnt_r >= 4'(MAX_EURO_DIGITS)) begin
          if (err_r == ST_OK) err_nxt = ST_TOO_LONG;
        end else begin
          cnt_nxt  = cnt_r + 4'd1;
          euro_nxt = {euro_r[20:0], 3'b000} + {euro_r[22:0], 1'b0} + 24'(digit);
        end
      end else begin
        if (cnt_r >= 4'd2) begin
          if (err_r == ST_OK) err_nxt = ST_CENT_DIGITS;
        end else begin
          cnt_nxt  = cnt_r + 4'd1;
          cent_nxt = {cent_r[3:0], 3'b000} + {cent_r[5:0], 1'b0} + 7'(digit);
        end
      end
    end else if (is_sep) begin
      if (frac_r) begin
        if (err_r == ST_OK) err_nxt = ST_BAD_CHAR;
      end else begin
        frac_nxt = 1'b1;
        cnt_nxt  = 4'd0;
      end
    end else begin
      if (err_r == ST_OK) err_nxt = ST_BAD_CHAR;
    end
  end

  // The last character closes the amount and checks the top note.
  always_comb begin
    push           = take && last_char;
    job.euro_total = euro_nxt;
    job.cent_total = cent_nxt;
    job.start_idx  = start_idx;
    if (err_nxt == ST_OK && start_idx == NO_TOP_IDX) begin
      job.error_code = ST_BAD_TOP;
    end else begin
      job.error_code = err_nxt;
    end
  end

  // Amount state; cleared after every last character.
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      euro_r <= '0;
      cent_r <= '0;
      frac_r <= 1'b0;
      err_r  <= ST_OK;
      cnt_r  <= '0;
    end else if (take) begin
      euro_r <= euro_nxt;
      cent_r <= cent_nxt;
      frac_r <= frac_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ sv/eacb_queue.sv @@
// Two-entry job queue between the parser and the breakdown engine.
`timescale 1ns / 1ps

module eacb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  eacb_pkg::job_t    push_job,
  input  logic              pop,
  output eacb_pkg::job_t    head_job,
  output logic              full,
  output logic              empty
);
  import eacb_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  // Storage for queued jobs.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

@@ sv/eacb_back.sv @@
// Breakdown engine: greedy division by each denomination through a reciprocal multiply.
`timescale 1ns / 1ps

module eacb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  eacb_pkg::job_t    q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_denom_index,
  output logic [23:0]       out_piece_count,
  output logic [2:0]        out_status,
  output logic              out_last
);
  import eacb_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_ERR, B_MUL, B_DIV} bstate_t;

  bstate_t     state_r;
  logic [3:0]  k_r;
  logic [3:0]  start_r;
  logic [2:0]  err_r;
  logic [6:0]  cent_r;
  logic [23:0] rest_r;
  logic [55:0] prod_r;
  logic        valid_r;
  logic [3:0]  idx_r;
  logic [23:0] count_r;
  logic [2:0]  status_r;
  logic        last_r;

  logic        slot_free;
  logic        emit;
  logic [8:0]  denom;
  logic [23:0] q_est;
  logic [32:0] qd_full;
  logic [23:0] r_est;
  logic [23:0] q_fix;
  logic [23:0] r_fix;

  assign slot_free       = !valid_r || out_ready;
  assign emit            = ((state_r == B_ERR) || (state_r == B_DIV)) && slot_free;
  assign q_pop           = (state_r == B_IDLE) && !q_empty;
  assign out_valid       = valid_r;
  assign out_denom_index = idx_r;
  assign out_piece_count = count_r;
  assign out_status      = status_r;
  assign out_last        = last_r;

  // Quotient correction: the estimate is low by at most one.
  always_comb begin
    denom   = denom_value(k_r);
    q_est   = prod_r[55:32];
    qd_full = 33'(q_est) * 33'(denom);
    r_est   = rest_r - qd_full[23:0];
    if (r_est >= 24'(denom)) begin
      q_fix = q_est + 24'd1;
      r_fix = r_est - 24'(denom);
    end else begin
      q_fix = q_est;
      r_fix = r_est;
    end
    if (k_r < start_r) begin
      q_fix = '0;
      r_fix = rest_r;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      if (emit) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            k_r     <= '0;
            start_r <= q_job.start_idx;
            err_r   <= q_job.error_code;
            cent_r  <= q_job.cent_total;
            rest_r  <= q_job.euro_total;
            state_r <= (q_job.error_code != ST_OK) ? B_ERR : B_MUL;
          end
        end
        B_ERR: begin
          if (slot_free) begin
            idx_r    <= '0;
            count_r  <= '0;
            status_r <= err_r;
            last_r   <= 1'b1;
            state_r  <= B_IDLE;
          end
        end
        B_MUL: begin
          prod_r  <= 56'(rest_r) * 56'(denom_recip(k_r));
          state_r <= B_DIV;
        end
        B_DIV: begin
          if (slot_free) begin
            idx_r    <= k_r;
            count_r  <= q_fix;
            status_r <= ST_OK;
            last_r   <= (k_r == LAST_DENOM_IDX);
            rest_r   <= (k_r == LAST_EURO_IDX) ? 24'(cent_r) : r_fix;
            k_r      <= k_r + 4'd1;
            state_r  <= (k_r == LAST_DENOM_IDX) ? B_IDLE : B_MUL;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

@@ sv/euro_amount_change_breakdown_unit.sv @@
// Top level of the euro amount change breakdown unit: parser, job queue and breakdown engine.
`timescale 1ns / 1ps

// Channel   Direction  Payload
// in_*      slave      tdata[7:0] char_code, tdata[16:8] top_note, tlast last_char
// out_*     master     tdata[3:0] denom_index, tdata[27:4] piece_count,
//                      tuser status, tlast last_result
//
// Characters are taken one per cycle while the two-entry job queue has room.
// A breakdown loads the job, then handles each denomination with a reciprocal multiply
// followed by a correction; each correction waits for a free output slot.
// An error amount is loaded, then sent as the error transfer.
// Reset (rst_n low, synchronous) clears the parser, the queue and the output valid flag.
// in_tready falls only while the queue holds two unfinished amounts; out_tready
// stalls the engine without affecting the parser.
module euro_amount_change_breakdown_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code [7:0], top_note [16:8], zeros
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // denom_index [3:0], piece_count [27:4], zeros
  output logic [2:0]  out_tuser,  // status [2:0]
  output logic        out_tlast
);
  import eacb_pkg::*;

  logic        take;
  logic        push;
  job_t        push_job;
  job_t        head_job;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic [3:0]  denom_index;
  logic [23:0] piece_count;

  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;
  assign out_tdata = {4'b0000, piece_count, denom_index};

  eacb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_code (in_tdata[7:0]),
    .last_char (in_tlast),
    .top_note  (in_tdata[16:8]),
    .push      (push),
    .job       (push_job)
  );

  eacb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  eacb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (head_job),
    .q_pop           (q_pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_denom_index (denom_index),
    .out_piece_count (piece_count),
    .out_status      (out_tuser),
    .out_last        (out_tlast)
  );

  // An error result is a single closing transfer with a zero count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tlast && piece_count == '0)
    else $error("error result is not a single closing transfer");

  // The denomination index never leaves the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> denom_index <= LAST_DENOM_IDX)
    else $error("denomination index out of range");

  // A closing ok result always belongs to the one-cent coin.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser == ST_OK |-> denom_index == LAST_DENOM_IDX)
    else $error("breakdown closed early");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
